// ----- sv/assert_macros.svh -----
// assertion helpers, all clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wsd_pkg.sv -----
package wsd_pkg;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT_HI  = 6'b000100,
    PH_EXT_LO  = 6'b001000,
    PH_KEY     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [1:0] KEY_LAST = 2'd3;

endpackage

// ----- sv/websocket_frame_deframer_core.sv -----
// WebSocket receive deframer: takes one stream byte per request and parses the
// frame header, extended 16-bit length and masking key, then unmasks payload
// bytes. Text payload bytes come out with a marker on the final byte, a close
// frame gives one close event after its payload, and a 64-bit length gives an
// error event; after either event all further bytes are accepted and dropped
// until reset. One byte is taken every clock cycle: the parser state updates
// in the cycle of acceptance and any result lands in a single output register
// in the next cycle, and the input stalls only while that register holds a
// result that is not being taken in the same cycle. No clearing pass is needed
// after reset.
`include "assert_macros.svh"

module websocket_frame_deframer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data,
  output logic       last_of_message
);

  wsd_pkg::phase_t phase, phase_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        is_masked, is_masked_next;
  logic [15:0] remaining_len, remaining_len_next;
  logic [7:0]  mask_key [4];
  logic [1:0]  byte_pos, byte_pos_next;
  logic        stopped, stopped_next;

  logic        in_accept;
  logic        key_we;
  logic        emit;
  logic [1:0]  emit_kind;
  logic [7:0]  emit_data;
  logic        emit_last;
  logic        after_len, start_body, end_frame;
  logic [15:0] body_len;
  logic [15:0] len_dec;
  logic [7:0]  unmasked;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign len_dec  = remaining_len - 16'd1;
  assign unmasked = is_masked ? (rx_byte ^ mask_key[byte_pos]) : rx_byte;

  always_comb begin
    phase_next         = phase;
    frame_opcode_next  = frame_opcode;
    is_masked_next     = is_masked;
    remaining_len_next = remaining_len;
    byte_pos_next      = byte_pos;
    stopped_next       = stopped;
    key_we             = 1'b0;
    emit               = 1'b0;
    emit_kind          = wsd_pkg::KIND_TEXT;
    emit_data          = 8'd0;
    emit_last          = 1'b0;
    after_len          = 1'b0;
    start_body         = 1'b0;
    end_frame          = 1'b0;
    body_len           = remaining_len;

    if (!stopped) begin
      unique case (phase)
        wsd_pkg::PH_HDR1: begin
          is_masked_next = rx_byte[7];
          if (rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
            stopped_next = 1'b1;
            phase_next   = wsd_pkg::PH_HDR0;
            emit         = 1'b1;
            emit_kind    = wsd_pkg::KIND_ERROR;
          end else if (rx_byte[6:0] == wsd_pkg::LEN_EXT16) begin
            phase_next = wsd_pkg::PH_EXT_HI;
          end else begin
            remaining_len_next = {9'd0, rx_byte[6:0]};
            body_len           = {9'd0, rx_byte[6:0]};
            after_len          = 1'b1;
          end
        end
        wsd_pkg::PH_EXT_HI: begin
          remaining_len_next = {rx_byte, 8'd0};
          phase_next         = wsd_pkg::PH_EXT_LO;
        end
        wsd_pkg::PH_EXT_LO: begin
          remaining_len_next = {remaining_len[15:8], rx_byte};
          body_len           = {remaining_len[15:8], rx_byte};
          after_len          = 1'b1;
        end
        wsd_pkg::PH_KEY: begin
          key_we = 1'b1;
          if (byte_pos == wsd_pkg::KEY_LAST) begin
            start_body = 1'b1;
          end else begin
            byte_pos_next = byte_pos + 2'd1;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          byte_pos_next      = byte_pos + 2'd1;
          remaining_len_next = len_dec;
          if (frame_opcode == wsd_pkg::OP_TEXT) begin
            emit      = 1'b1;
            emit_kind = wsd_pkg::KIND_TEXT;
            emit_data = unmasked;
          end
          if (len_dec == 16'd0) begin
            if (frame_opcode == wsd_pkg::OP_TEXT) begin
              emit_last  = 1'b1;
              phase_next = wsd_pkg::PH_HDR0;
            end else begin
              end_frame = 1'b1;
            end
          end
        end
        default: begin
          frame_opcode_next = rx_byte[3:0];
          phase_next        = wsd_pkg::PH_HDR1;
        end
      endcase

      // masked flag as it stands after this byte
      if (after_len) begin
        if (is_masked_next) begin
          byte_pos_next = 2'd0;
          phase_next    = wsd_pkg::PH_KEY;
        end else begin
          start_body = 1'b1;
        end
      end

      if (start_body) begin
        byte_pos_next = 2'd0;
        if (body_len == 16'd0) begin
          end_frame = 1'b1;
        end else begin
          phase_next = wsd_pkg::PH_PAYLOAD;
        end
      end

      if (end_frame) begin
        phase_next = wsd_pkg::PH_HDR0;
        if (frame_opcode == wsd_pkg::OP_CLOSE) begin
          stopped_next = 1'b1;
          emit         = 1'b1;
          emit_kind    = wsd_pkg::KIND_CLOSE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wsd_pkg::PH_HDR0;
      frame_opcode  <= 4'd0;
      is_masked     <= 1'b0;
      remaining_len <= 16'd0;
      byte_pos      <= 2'd0;
      stopped       <= 1'b0;
    end else if (in_accept) begin
      phase         <= phase_next;
      frame_opcode  <= frame_opcode_next;
      is_masked     <= is_masked_next;
      remaining_len <= remaining_len_next;
      byte_pos      <= byte_pos_next;
      stopped       <= stopped_next;
    end
  end

  // key store written one byte per request
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_key[0] <= 8'd0;
      mask_key[1] <= 8'd0;
      mask_key[2] <= 8'd0;
      mask_key[3] <= 8'd0;
    end else if (in_accept && key_we) begin
      mask_key[byte_pos] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      kind            <= emit_kind;
      data            <= emit_data;
      last_of_message <= emit_last;
    end
  end

  `ASSERT_NEXT(a_stop_sticks, stopped, stopped, "parser left the stopped state without reset")
  `ASSERT_NEXT(a_event_stops, in_accept && emit && emit_kind != wsd_pkg::KIND_TEXT,
               stopped, "close or error event did not stop the parser")
  `ASSERT_NEXT(a_stopped_silent, stopped && in_accept, !out_valid,
               "result produced after stop")
  `ASSERT_IMPL(a_event_fields, out_valid && kind != wsd_pkg::KIND_TEXT,
               data == 8'd0 && !last_of_message, "event result carries payload bits")

endmodule
